>>> hw/rtl/rkc_pkg.sv
`timescale 1ns / 1ps
package rkc_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_MAX_KERNEL = 9;

  localparam int PIX_W     = 8;
  localparam int PIX_MAX   = 255;
  localparam int RGB_W     = 3 * PIX_W;
  localparam int COEF_W    = 8;
  localparam int OP_W      = 2;
  localparam int KIDX_W    = 4;
  localparam int KSIZE_W   = 4;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int LO_W      = 3;

  localparam logic [OP_W-1:0] OP_COEF  = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [KSIZE_W-1:0]  DEF_KSIZE  = 4'd3;
  localparam logic [WIDTH_W-1:0]  DEF_WIDTH  = 11'd640;
  localparam logic [HEIGHT_W-1:0] DEF_HEIGHT = 13'd480;

  // accumulator holds taps * coefficient * pixel, signed
  function automatic int acc_width(int k);
    return $clog2(k * k * 128 * PIX_MAX) + 1;
  endfunction

  function automatic int ksum_width(int k);
    return $clog2(k * k * 128) + 1;
  endfunction

  typedef struct packed {
    logic              accept;
    logic              start;
    logic              rewind;
    logic              tap;
    logic              row_end;
    logic [KIDX_W-1:0] tap_i;
    logic [KIDX_W-1:0] tap_j;
    logic              div_load;
    logic              div_step;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic               item_emits;
    logic [KSIZE_W-1:0] size;
    logic [LO_W-1:0]    rewind_len;
    logic               out_free;
  } stat_t;

endpackage

>>> hw/rtl/rkc_ram.sv
`timescale 1ns / 1ps
module rkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/rkc_ctrl.sv
`timescale 1ns / 1ps
module rkc_ctrl #(
  parameter int MAX_KERNEL = rkc_pkg::DEF_MAX_KERNEL
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           cfg_we,
  input  rkc_pkg::stat_t stat,
  output rkc_pkg::cmd_t  cmd
);
  import rkc_pkg::*;

  localparam int DIV_STEPS = acc_width(MAX_KERNEL) - 1;
  localparam int DC_W      = $clog2(DIV_STEPS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REWIND = 3'd1;
  localparam logic [2:0] S_TAPS   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DIVLD  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [LO_W-1:0]   rw_cnt_r, rw_cnt_nxt;
  logic [KIDX_W-1:0] ti_r, ti_nxt, tj_r, tj_nxt;
  logic [DC_W-1:0]   dcnt_r, dcnt_nxt;
  logic [1:0]        settle_r, settle_nxt;
  logic [KSIZE_W-1:0] last_idx;

  assign last_idx = stat.size - KSIZE_W'(1);
  assign in_ready = (state_r == S_IDLE) && (settle_r == 2'd0);

  always_comb begin
    state_nxt  = state_r;
    rw_cnt_nxt = rw_cnt_r;
    ti_nxt     = ti_r;
    tj_nxt     = tj_r;
    dcnt_nxt   = dcnt_r;
    settle_nxt = (settle_r != 2'd0) ? settle_r - 2'd1 : 2'd0;
    if (cfg_we) begin
      settle_nxt = 2'd3;
    end
    cmd       = '0;
    cmd.tap_i = ti_r;
    cmd.tap_j = tj_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (stat.item_emits) begin
            cmd.start  = 1'b1;
            rw_cnt_nxt = '0;
            ti_nxt     = '0;
            tj_nxt     = '0;
            state_nxt  = S_REWIND;
          end
        end
      end
      S_REWIND: begin
        if (rw_cnt_r == stat.rewind_len) begin
          state_nxt = S_TAPS;
        end else begin
          cmd.rewind = 1'b1;
          rw_cnt_nxt = rw_cnt_r + LO_W'(1);
        end
      end
      S_TAPS: begin
        cmd.tap = 1'b1;
        if (tj_r == last_idx) begin
          cmd.row_end = 1'b1;
          tj_nxt      = '0;
          if (ti_r == last_idx) begin
            state_nxt = S_DRAIN;
          end else begin
            ti_nxt = ti_r + KIDX_W'(1);
          end
        end else begin
          tj_nxt = tj_r + KIDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DC_W'(1);
        if (dcnt_r == DC_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rw_cnt_r <= '0;
      ti_r     <= '0;
      tj_r     <= '0;
      dcnt_r   <= '0;
      settle_r <= 2'd3;
    end else begin
      state_r  <= state_nxt;
      rw_cnt_r <= rw_cnt_nxt;
      ti_r     <= ti_nxt;
      tj_r     <= tj_nxt;
      dcnt_r   <= dcnt_nxt;
      settle_r <= settle_nxt;
    end
  end

endmodule

>>> hw/rtl/rkc_datapath.sv
`timescale 1ns / 1ps
module rkc_datapath #(
  parameter int MAX_WIDTH  = rkc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rkc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = rkc_pkg::DEF_MAX_KERNEL
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rkc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rkc_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [rkc_pkg::OP_W-1:0]          in_operation,
  input  logic [rkc_pkg::KIDX_W-1:0]        in_coef_row,
  input  logic [rkc_pkg::KIDX_W-1:0]        in_coef_col,
  input  logic signed [rkc_pkg::COEF_W-1:0] in_coef_value,
  input  logic [rkc_pkg::PIX_W-1:0]         in_red_in,
  input  logic [rkc_pkg::PIX_W-1:0]         in_green_in,
  input  logic [rkc_pkg::PIX_W-1:0]         in_blue_in,
  input  rkc_pkg::cmd_t                     cmd,
  output rkc_pkg::stat_t                    stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rkc_pkg::PIX_W-1:0]         out_red_out,
  output logic [rkc_pkg::PIX_W-1:0]         out_green_out,
  output logic [rkc_pkg::PIX_W-1:0]         out_blue_out,
  output logic                              out_end_of_frame
);
  import rkc_pkg::*;

  localparam int LINE_DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int AW     = $clog2(LINE_DEPTH);
  localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int UW_W   = $clog2(MAX_WIDTH + 1);
  localparam int UH_W   = $clog2(MAX_HEIGHT + 1);
  localparam int KTAPS  = MAX_KERNEL * MAX_KERNEL;
  localparam int KA_W   = $clog2(KTAPS);
  localparam int ACC_W  = acc_width(MAX_KERNEL);
  localparam int KS_W   = ksum_width(MAX_KERNEL);
  localparam int MAG_W  = ACC_W - 1;
  localparam int DV_W   = KS_W - 1;
  localparam int CC_W   = COL_W + 2;
  localparam int RR_W   = ROW_W + 2;
  localparam int PROD_W = COEF_W + PIX_W + 1;

  // configuration and derived frame geometry
  logic [KSIZE_W-1:0]  ks_r;
  logic [WIDTH_W-1:0]  iw_r;
  logic [HEIGHT_W-1:0] ih_r;
  logic [KSIZE_W-1:0]  u_size_r, u_size_nxt;
  logic [UW_W-1:0]     u_w_r, u_w_nxt;
  logic [UH_W-1:0]     u_h_r, u_h_nxt;
  logic [LO_W-1:0]     lo, hi;
  logic [CNT_W-1:0]    total_r, delay_r;

  logic [CNT_W-1:0] rcv_r, rcv_nxt, emt_r, emt_nxt;
  logic [ROW_W-1:0] er_r, er_nxt;
  logic [COL_W-1:0] ec_r, ec_nxt;
  logic [AW-1:0]    ebase_r, ebase_nxt, wptr_r, wptr_nxt, rb_r, rb_nxt;

  logic op_coef, op_pix, op_flush, full, can_flush, pix_emit, eof, cfg_restart;
  logic pix_write;

  assign lo = LO_W'(u_size_r >> 1);
  assign hi = LO_W'(u_size_r - KSIZE_W'(1) - KSIZE_W'(lo));

  always_comb begin
    u_size_nxt = ks_r;
    if (ks_r < KSIZE_W'(3)) begin
      u_size_nxt = KSIZE_W'(3);
    end else if (32'(ks_r) > MAX_KERNEL) begin
      u_size_nxt = KSIZE_W'(MAX_KERNEL);
    end
    u_w_nxt = UW_W'(iw_r);
    if (iw_r == '0) begin
      u_w_nxt = UW_W'(1);
    end else if (32'(iw_r) > MAX_WIDTH) begin
      u_w_nxt = UW_W'(MAX_WIDTH);
    end
    u_h_nxt = UH_W'(ih_r);
    if (ih_r == '0) begin
      u_h_nxt = UH_W'(1);
    end else if (32'(ih_r) > MAX_HEIGHT) begin
      u_h_nxt = UH_W'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r <= DEF_KSIZE;
      iw_r <= DEF_WIDTH;
      ih_r <= DEF_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_SIZE:  ks_r <= cfg_wdata[KSIZE_W-1:0];
        CFG_IMAGE_WIDTH:  iw_r <= cfg_wdata[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: ih_r <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry is registered after a write; the controller waits for it
  always_ff @(posedge clk) begin
    u_size_r <= u_size_nxt;
    u_w_r    <= u_w_nxt;
    u_h_r    <= u_h_nxt;
    total_r  <= CNT_W'(u_w_r) * CNT_W'(u_h_r);
    delay_r  <= CNT_W'(hi) * CNT_W'(u_w_r) + CNT_W'(hi);
  end

  assign cfg_restart = cfg_we && ((cfg_index == CFG_KERNEL_SIZE) ||
                                  (cfg_index == CFG_IMAGE_WIDTH) ||
                                  (cfg_index == CFG_IMAGE_HEIGHT));

  assign op_coef   = (in_operation == OP_COEF);
  assign op_pix    = (in_operation == OP_PIXEL);
  assign op_flush  = (in_operation == OP_FLUSH);
  assign full      = (rcv_r >= total_r);
  assign can_flush = full && (emt_r < total_r);
  assign pix_emit  = ({1'b0, rcv_r} + (CNT_W+1)'(1)) > ({1'b0, emt_r} + {1'b0, delay_r});
  assign pix_write = cmd.accept && op_pix && !full;
  assign eof       = ({1'b0, emt_r} + (CNT_W+1)'(1)) >= {1'b0, total_r};

  assign stat.item_emits = (op_pix && (full ? can_flush : pix_emit)) ||
                           (op_flush && can_flush);
  assign stat.size       = u_size_r;
  assign stat.rewind_len = (32'(er_r) < 32'(lo)) ? LO_W'(er_r) : lo;

  // tap address generation
  logic [CC_W-1:0]  cc_u;
  logic [COL_W-1:0] cc;
  logic [RR_W-1:0]  rt;
  logic             row_adv;
  logic [AW:0]      addr_sum, rb_plus_w, eb_plus_w;
  logic [AW-1:0]    line_raddr, rb_minus_w;

  always_comb begin
    cc_u = {2'b00, ec_r} + CC_W'(cmd.tap_j) - CC_W'(lo);
    if (cc_u[CC_W-1]) begin
      cc = '0;
    end else if (32'(cc_u) > 32'(u_w_r) - 1) begin
      cc = COL_W'(u_w_r - UW_W'(1));
    end else begin
      cc = COL_W'(cc_u);
    end
    addr_sum   = {1'b0, rb_r} + (AW+1)'(cc);
    line_raddr = (addr_sum >= (AW+1)'(LINE_DEPTH)) ?
                 AW'(addr_sum - (AW+1)'(LINE_DEPTH)) : AW'(addr_sum);
    // the next kernel row reads a new image row unless clamped at an edge
    rt      = {2'b00, er_r} + RR_W'(cmd.tap_i) + RR_W'(1) - RR_W'(lo);
    row_adv = !rt[RR_W-1] && (rt != '0) && (32'(rt) <= 32'(u_h_r) - 1);
    rb_plus_w  = {1'b0, rb_r} + (AW+1)'(u_w_r);
    rb_minus_w = ((AW+1)'(rb_r) >= (AW+1)'(u_w_r)) ?
                 AW'((AW+1)'(rb_r) - (AW+1)'(u_w_r)) :
                 AW'((AW+1)'(rb_r) + (AW+1)'(LINE_DEPTH) - (AW+1)'(u_w_r));
    eb_plus_w  = {1'b0, ebase_r} + (AW+1)'(u_w_r);
  end

  // frame counters
  always_comb begin
    rcv_nxt   = rcv_r;
    emt_nxt   = emt_r;
    er_nxt    = er_r;
    ec_nxt    = ec_r;
    ebase_nxt = ebase_r;
    wptr_nxt  = wptr_r;
    rb_nxt    = rb_r;
    if (pix_write) begin
      rcv_nxt  = rcv_r + CNT_W'(1);
      wptr_nxt = (32'(wptr_r) == LINE_DEPTH - 1) ? '0 : wptr_r + AW'(1);
    end
    if (cmd.start) begin
      rb_nxt = ebase_r;
    end else if (cmd.rewind) begin
      rb_nxt = rb_minus_w;
    end else if (cmd.tap && cmd.row_end && row_adv) begin
      rb_nxt = (rb_plus_w >= (AW+1)'(LINE_DEPTH)) ?
               AW'(rb_plus_w - (AW+1)'(LINE_DEPTH)) : AW'(rb_plus_w);
    end
    if (cmd.out_load) begin
      emt_nxt = emt_r + CNT_W'(1);
      if (32'(ec_r) == 32'(u_w_r) - 1) begin
        ec_nxt    = '0;
        er_nxt    = er_r + ROW_W'(1);
        ebase_nxt = (eb_plus_w >= (AW+1)'(LINE_DEPTH)) ?
                    AW'(eb_plus_w - (AW+1)'(LINE_DEPTH)) : AW'(eb_plus_w);
      end else begin
        ec_nxt = ec_r + COL_W'(1);
      end
    end
    if (cfg_restart || (cmd.out_load && eof)) begin
      rcv_nxt   = '0;
      emt_nxt   = '0;
      er_nxt    = '0;
      ec_nxt    = '0;
      ebase_nxt = '0;
      wptr_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcv_r   <= '0;
      emt_r   <= '0;
      er_r    <= '0;
      ec_r    <= '0;
      ebase_r <= '0;
      wptr_r  <= '0;
      rb_r    <= '0;
    end else begin
      rcv_r   <= rcv_nxt;
      emt_r   <= emt_nxt;
      er_r    <= er_nxt;
      ec_r    <= ec_nxt;
      ebase_r <= ebase_nxt;
      wptr_r  <= wptr_nxt;
      rb_r    <= rb_nxt;
    end
  end

  // stores
  logic [RGB_W-1:0]  line_q;
  logic [COEF_W-1:0] kq;
  logic [KTAPS-1:0]  kvalid_r;
  logic              kv_q_r, mac_en_r, kwe;
  logic [KA_W-1:0]   kwaddr, kraddr;

  assign kwe    = cmd.accept && op_coef && (32'(in_coef_row) < MAX_KERNEL) &&
                  (32'(in_coef_col) < MAX_KERNEL);
  assign kwaddr = KA_W'(32'(in_coef_row) * MAX_KERNEL + 32'(in_coef_col));
  assign kraddr = KA_W'(32'(cmd.tap_i) * MAX_KERNEL + 32'(cmd.tap_j));

  rkc_ram #(.WIDTH(RGB_W), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (pix_write),
    .waddr (wptr_r),
    .wdata ({in_red_in, in_green_in, in_blue_in}),
    .raddr (line_raddr),
    .rdata (line_q)
  );

  rkc_ram #(.WIDTH(COEF_W), .DEPTH(KTAPS)) u_kernel_ram (
    .clk   (clk),
    .we    (kwe),
    .waddr (kwaddr),
    .wdata (in_coef_value),
    .raddr (kraddr),
    .rdata (kq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kvalid_r <= '0;
      mac_en_r <= 1'b0;
    end else begin
      if (kwe) begin
        kvalid_r[kwaddr] <= 1'b1;
      end
      mac_en_r <= cmd.tap;
    end
    kv_q_r <= kvalid_r[kraddr];
  end

  // multiply-accumulate, one tap per cycle for all three channels
  logic signed [COEF_W-1:0] coef;
  logic signed [ACC_W-1:0]  acc_r [3];
  logic signed [KS_W-1:0]   ksum_r;
  logic signed [PROD_W-1:0] prod [3];

  assign coef = kv_q_r ? $signed(kq) : '0;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PROD_W'(coef) *
                $signed({1'b0, line_q[RGB_W-1-PIX_W*c -: PIX_W]});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
      end
      ksum_r <= '0;
    end else if (mac_en_r) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod[c]);
      end
      ksum_r <= ksum_r + KS_W'(coef);
    end
  end

  // restoring division of magnitudes, one quotient bit per cycle per channel
  logic [MAG_W-1:0]  num_r [3];
  logic [DV_W-1:0]   rem_r [3];
  logic              neg_r [3];
  logic [DV_W-1:0]   dvs_r;
  logic [DV_W:0]     rem_sh [3];
  logic [MAG_W-1:0]  num_nxt [3];
  logic [DV_W-1:0]   rem_nxt [3];
  logic [PIX_W-1:0]  chan [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem_sh[c] = {rem_r[c], num_r[c][MAG_W-1]};
      if (rem_sh[c] >= {1'b0, dvs_r}) begin
        rem_nxt[c] = DV_W'(rem_sh[c] - {1'b0, dvs_r});
        num_nxt[c] = {num_r[c][MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt[c] = DV_W'(rem_sh[c]);
        num_nxt[c] = {num_r[c][MAG_W-2:0], 1'b0};
      end
      // a negative quotient clamps to zero
      if (neg_r[c]) begin
        chan[c] = '0;
      end else if (32'(num_r[c]) > PIX_MAX) begin
        chan[c] = PIX_W'(PIX_MAX);
      end else begin
        chan[c] = PIX_W'(num_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      if (ksum_r == '0) begin
        dvs_r <= DV_W'(1);
      end else begin
        dvs_r <= ksum_r[KS_W-1] ? DV_W'(-ksum_r) : DV_W'(ksum_r);
      end
      for (int c = 0; c < 3; c++) begin
        num_r[c] <= acc_r[c][ACC_W-1] ? MAG_W'(-acc_r[c]) : MAG_W'(acc_r[c]);
        rem_r[c] <= '0;
        neg_r[c] <= acc_r[c][ACC_W-1] ^ ksum_r[KS_W-1];
      end
    end else if (cmd.div_step) begin
      for (int c = 0; c < 3; c++) begin
        num_r[c] <= num_nxt[c];
        rem_r[c] <= rem_nxt[c];
      end
    end
  end

  // output register
  logic out_valid_r;

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_red_out      <= chan[0];
      out_green_out    <= chan[1];
      out_blue_out     <= chan[2];
      out_end_of_frame <= eof;
    end
  end

endmodule

>>> hw/rtl/rgb_kernel_convolution.sv
`timescale 1ns / 1ps
// Streaming RGB convolution with a square kernel of 3 to 9 taps per side.
// Input channel (in_valid/in_ready): one transaction per item; operation
// selects a coefficient write, a pixel, or a flush of one pending output.
// Output channel (out_valid/out_ready): one transaction per filtered pixel,
// with out_end_of_frame on the last pixel of a frame.
// Configuration: cfg_we with cfg_index/cfg_wdata, written while idle; a write
// of size, width or height restarts the frame, and after any write in_ready
// stays low while the geometry settles. An item that yields no output leaves
// the controller idle. An item that yields one, with in_ready low throughout,
// runs r = min(n/2, output row) line rewinds for an n x n kernel, a walk of
// the taps by the multiply-accumulate with one line-store read per tap, a
// drain, a 22-step restoring divider per channel and the output load.
// Outputs trail the input by (n-1-n/2) rows plus as many pixels; flushes
// drain the rest after the frame is complete.
// Reset: kernel reads as all zero, size 3, 640 x 480, in_ready low while
// geometry settles. A stalled receiver holds the result in the output register;
// the next item is still taken, and a further result waits for the register.
module rgb_kernel_convolution #(
  parameter int MAX_WIDTH  = rkc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rkc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = rkc_pkg::DEF_MAX_KERNEL
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rkc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rkc_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rkc_pkg::OP_W-1:0]          in_operation,
  input  logic [rkc_pkg::KIDX_W-1:0]        in_coef_row,
  input  logic [rkc_pkg::KIDX_W-1:0]        in_coef_col,
  input  logic signed [rkc_pkg::COEF_W-1:0] in_coef_value,
  input  logic [rkc_pkg::PIX_W-1:0]         in_red_in,
  input  logic [rkc_pkg::PIX_W-1:0]         in_green_in,
  input  logic [rkc_pkg::PIX_W-1:0]         in_blue_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rkc_pkg::PIX_W-1:0]         out_red_out,
  output logic [rkc_pkg::PIX_W-1:0]         out_green_out,
  output logic [rkc_pkg::PIX_W-1:0]         out_blue_out,
  output logic                              out_end_of_frame
);
  import rkc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rkc_ctrl #(.MAX_KERNEL(MAX_KERNEL)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg_we   (cfg_we),
    .stat     (stat),
    .cmd      (cmd)
  );

  rkc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_operation     (in_operation),
    .in_coef_row      (in_coef_row),
    .in_coef_col      (in_coef_col),
    .in_coef_value    (in_coef_value),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

>>> hw/rtl/rkc_checker.sv
`timescale 1ns / 1ps
module rkc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_we,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [rkc_pkg::OP_W-1:0]      in_operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rkc_pkg::PIX_W-1:0]     out_red_out,
  input logic [rkc_pkg::PIX_W-1:0]     out_green_out,
  input logic [rkc_pkg::PIX_W-1:0]     out_blue_out,
  input logic                          out_end_of_frame
);
  import rkc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_out) &&
    $stable(out_green_out) && $stable(out_blue_out) && $stable(out_end_of_frame))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken while geometry settles");

  a_coef_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_COEF) && !cfg_we |=> in_ready)
    else $error("coefficient write did not return to idle");

endmodule

bind rgb_kernel_convolution rkc_checker u_rkc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_we           (cfg_we),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_operation     (in_operation),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_red_out      (out_red_out),
  .out_green_out    (out_green_out),
  .out_blue_out     (out_blue_out),
  .out_end_of_frame (out_end_of_frame)
);
